// ===== design/clcd_pkg.sv =====
// Shared types and constants for the character display nibble bus master.
package clcd_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int WORD_W      = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_FUNCTION    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISPLAY_OFF = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLEAR       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISPLAY_ON  = 3'd4;

    localparam logic [WORD_W-1:0] RST_FUNCTION    = 8'h28;
    localparam logic [WORD_W-1:0] RST_DISPLAY_OFF = 8'h08;
    localparam logic [WORD_W-1:0] RST_CLEAR       = 8'h01;
    localparam logic [WORD_W-1:0] RST_ENTRY       = 8'h06;
    localparam logic [WORD_W-1:0] RST_DISPLAY_ON  = 8'h0C;

    localparam int INIT_COMMANDS = 5;
    localparam int STEP_W        = 3;
    localparam int BUSY_BIT      = 7;

    // Request modes
    localparam logic [1:0] MODE_CMD    = 2'd0;
    localparam logic [1:0] MODE_DATA   = 2'd1;
    localparam logic [1:0] MODE_STATUS = 2'd2;
    localparam logic [1:0] MODE_INIT   = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_WRITE    = 2'd0;
    localparam logic [1:0] KIND_READ     = 2'd1;
    localparam logic [1:0] KIND_FINISHED = 2'd2;
    localparam logic [1:0] KIND_REFUSED  = 2'd3;

    // Pause codes
    localparam logic [1:0] PAUSE_NONE     = 2'd0;
    localparam logic [1:0] PAUSE_POWER_UP = 2'd1;
    localparam logic [1:0] PAUSE_WAKE     = 2'd2;
    localparam logic [1:0] PAUSE_MODE     = 2'd3;

    localparam logic [3:0] WAKE_NIBBLE = 4'h3;
    localparam logic [3:0] MODE_NIBBLE = 4'h2;

    // Job codes passed from front to back
    localparam logic [2:0] OP_REFUSED  = 3'd0;
    localparam logic [2:0] OP_FINISHED = 3'd1;
    localparam logic [2:0] OP_READS    = 3'd2;
    localparam logic [2:0] OP_BYTE     = 3'd3;
    localparam logic [2:0] OP_INIT     = 3'd4;

    // Strobe slots of the longest sequence; shorter jobs start part way in
    localparam logic [2:0] SLOT_POWER_WAKE = 3'd0;
    localparam logic [2:0] SLOT_WAKE_A     = 3'd1;
    localparam logic [2:0] SLOT_WAKE_B     = 3'd2;
    localparam logic [2:0] SLOT_MODE_NIB   = 3'd3;
    localparam logic [2:0] SLOT_HIGH       = 3'd4;
    localparam logic [2:0] SLOT_LOW        = 3'd5;
    localparam logic [2:0] SLOT_READ_A     = 3'd6;
    localparam logic [2:0] SLOT_READ_B     = 3'd7;

    localparam int OUT_DATA_W = 16;

    typedef struct packed {
        logic [2:0]        op;
        logic              rs;
        logic [WORD_W-1:0] byte_val;
    } t_job;

endpackage

// ===== design/clcd_front.sv =====
// Front part: holds init words, tracks busy polling and turns requests into jobs.
module clcd_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [clcd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [clcd_pkg::WORD_W-1:0]      i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [1:0]                       i_mode,
    input  logic [clcd_pkg::WORD_W-1:0]      i_byte,
    input  logic                             i_q_ready,
    output logic                             o_push,
    output clcd_pkg::t_job                   o_job
);
    import clcd_pkg::*;

    localparam logic PH_IDLE = 1'b0;
    localparam logic PH_WAIT = 1'b1;

    logic [WORD_W-1:0] r_word [INIT_COMMANDS];
    logic              r_phase, n_phase;
    logic              r_in_init, n_in_init;
    logic [STEP_W-1:0] r_step, n_step;
    logic [STEP_W-1:0] step_inc;
    logic [WORD_W-1:0] next_word;
    logic              accept;

    assign o_ready  = i_q_ready;
    assign accept   = i_valid && i_q_ready;
    assign step_inc = r_step + STEP_W'(1);

    always_comb begin
        unique case (step_inc)
            3'd1:    next_word = r_word[1];
            3'd2:    next_word = r_word[2];
            3'd3:    next_word = r_word[3];
            default: next_word = r_word[4];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word[0] <= RST_FUNCTION;
            r_word[1] <= RST_DISPLAY_OFF;
            r_word[2] <= RST_CLEAR;
            r_word[3] <= RST_ENTRY;
            r_word[4] <= RST_DISPLAY_ON;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FUNCTION:    r_word[0] <= i_cfg_data;
                CFG_DISPLAY_OFF: r_word[1] <= i_cfg_data;
                CFG_CLEAR:       r_word[2] <= i_cfg_data;
                CFG_ENTRY:       r_word[3] <= i_cfg_data;
                CFG_DISPLAY_ON:  r_word[4] <= i_cfg_data;
                default: ;  // pause lengths belong to the downstream timer
            endcase
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_in_init = r_in_init;
        n_step    = r_step;
        o_push    = 1'b0;
        o_job     = '{op: OP_READS, rs: 1'b0, byte_val: '0};
        if (accept) begin
            priority if (i_mode == MODE_STATUS) begin
                if (r_phase == PH_WAIT) begin
                    priority if (i_byte[BUSY_BIT]) begin
                        o_push = 1'b1;
                    end else if (r_in_init) begin
                        if (step_inc < STEP_W'(INIT_COMMANDS)) begin
                            n_step = step_inc;
                            o_push = 1'b1;
                            o_job  = '{op: OP_BYTE, rs: 1'b0, byte_val: next_word};
                        end else begin
                            n_in_init = 1'b0;
                            n_step    = '0;
                            n_phase   = PH_IDLE;
                            o_push    = 1'b1;
                            o_job.op  = OP_FINISHED;
                        end
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end else if (r_phase == PH_WAIT) begin
                o_push   = 1'b1;
                o_job.op = OP_REFUSED;
            end else if (i_mode == MODE_INIT) begin
                n_in_init = 1'b1;
                n_step    = '0;
                n_phase   = PH_WAIT;
                o_push    = 1'b1;
                o_job     = '{op: OP_INIT, rs: 1'b0, byte_val: r_word[0]};
            end else begin
                n_in_init = 1'b0;
                n_step    = '0;
                n_phase   = PH_WAIT;
                o_push    = 1'b1;
                o_job     = '{op: OP_BYTE, rs: (i_mode == MODE_DATA), byte_val: i_byte};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_in_init <= 1'b0;
            r_step    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_in_init <= n_in_init;
            r_step    <= n_step;
        end
    end

    a_refuse_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_job.op == OP_REFUSED) |-> r_phase == PH_WAIT)
        else $error("refused job while not polling");
    a_init_polls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_init |-> r_phase == PH_WAIT)
        else $error("init sequence active without busy poll");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step < STEP_W'(INIT_COMMANDS))
        else $error("init step out of range");

endmodule

// ===== design/clcd_queue.sv =====
// Short show-ahead job queue between front and back.
module clcd_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  clcd_pkg::t_job i_job,
    output logic           o_not_full,
    input  logic           i_pop,
    output logic           o_valid,
    output clcd_pkg::t_job o_job
);
    import clcd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_not_full = (r_count != CNT_W'(DEPTH));
    assign o_valid    = (r_count != '0);
    assign o_job      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_not_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule

// ===== design/clcd_back.sv =====
// Back part: expands each job into bus strobes and reports, one result per cycle unless stalled.
module clcd_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  clcd_pkg::t_job                     i_job,
    output logic                               o_pop,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [clcd_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    output logic                               o_m_axis_tlast
);
    import clcd_pkg::*;

    logic        r_active;
    logic [2:0]  r_slot;
    logic [2:0]  start_slot, cur_slot;
    logic        load;
    logic [1:0]  n_kind, n_pause;
    logic        n_rs, n_last;
    logic [3:0]  n_nibble;
    logic        r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic        r_out_last;

    always_comb begin
        unique case (i_job.op)
            OP_INIT: start_slot = SLOT_POWER_WAKE;
            OP_BYTE: start_slot = SLOT_HIGH;
            default: start_slot = SLOT_READ_A;
        endcase
    end

    assign cur_slot = r_active ? r_slot : start_slot;
    assign load     = i_q_valid && (!r_out_valid || i_m_axis_tready);
    assign o_pop    = load && n_last;

    always_comb begin
        n_kind   = KIND_WRITE;
        n_rs     = 1'b0;
        n_nibble = '0;
        n_pause  = PAUSE_NONE;
        n_last   = 1'b0;
        priority if (i_job.op == OP_REFUSED) begin
            n_kind = KIND_REFUSED;
            n_last = 1'b1;
        end else if (i_job.op == OP_FINISHED) begin
            n_kind = KIND_FINISHED;
            n_last = 1'b1;
        end else begin
            unique case (cur_slot)
                SLOT_POWER_WAKE: begin
                    n_nibble = WAKE_NIBBLE;
                    n_pause  = PAUSE_POWER_UP;
                end
                SLOT_WAKE_A, SLOT_WAKE_B: begin
                    n_nibble = WAKE_NIBBLE;
                    n_pause  = PAUSE_WAKE;
                end
                SLOT_MODE_NIB: begin
                    n_nibble = MODE_NIBBLE;
                    n_pause  = PAUSE_WAKE;
                end
                SLOT_HIGH: begin
                    n_rs     = i_job.rs;
                    n_nibble = i_job.byte_val[7:4];
                    // the first init command waits out the mode gap
                    n_pause  = (i_job.op == OP_INIT) ? PAUSE_MODE : PAUSE_NONE;
                end
                SLOT_LOW: begin
                    n_rs     = i_job.rs;
                    n_nibble = i_job.byte_val[3:0];
                end
                SLOT_READ_A: begin
                    n_kind = KIND_READ;
                end
                default: begin
                    n_kind = KIND_READ;
                    n_last = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_active    <= !n_last;
                r_slot      <= cur_slot + 3'd1;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= {(OUT_DATA_W - 9)'(0), n_pause, n_nibble, n_rs, n_kind};
            r_out_last <= n_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    a_pop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (o_m_axis_tvalid && o_m_axis_tlast))
        else $error("job retired without a last result");
    a_active_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> i_q_valid)
        else $error("sequence running with empty queue");
    a_active_multi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (i_job.op == OP_INIT || i_job.op == OP_BYTE || i_job.op == OP_READS))
        else $error("single-result job left running");

endmodule

// ===== design/char_lcd_nibble_bus_master_core.sv =====
// Top level of the character display 4-bit bus master.
//
// Requests come in on the slave stream: tuser carries the mode (command write,
// data write, status returned, start init), tdata the byte. Results leave on
// the master stream, one bus strobe or status report per transfer, with tlast
// on the final result that a request causes. The pause code in each result
// tells the downstream timer how long to wait before the strobe; the pause
// lengths at configuration indexes 5 to 7 are for that timer and are not held
// here. Indexes 0 to 4 set the five init command bytes.
//
// A request is classified in the cycle it is taken and its job lands in a
// four-entry queue, from which the back end registers its results in the
// single output register, one result per cycle while the receiver takes them;
// a write yields four results and an init request eight. Requests keep
// coming in while the queue has room, also when the receiver stalls; tready
// drops only when the queue is full. Reset empties the queue and output and
// restores the default init bytes; no clearing pass is needed.
module char_lcd_nibble_bus_master_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [clcd_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [clcd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [7:0]                          i_s_axis_tdata,  // [7:0] byte_value
    input  logic [1:0]                          i_s_axis_tuser,  // [1:0] mode
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [1:0] kind, [2] reg_select, [6:3] nibble, [8:7] pause_before, rest zero
    output logic [clcd_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    output logic                                o_m_axis_tlast
);
    import clcd_pkg::*;

    logic q_not_full, q_valid, push, pop;
    t_job push_job, head_job;

    clcd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data[WORD_W-1:0]),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_mode      (i_s_axis_tuser),
        .i_byte      (i_s_axis_tdata),
        .i_q_ready   (q_not_full),
        .o_push      (push),
        .o_job       (push_job)
    );

    clcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (push_job),
        .o_not_full (q_not_full),
        .i_pop      (pop),
        .o_valid    (q_valid),
        .o_job      (head_job)
    );

    clcd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_job           (head_job),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule
